/* design/hsrm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and constant tables of the harmonic-sum ring modulator.
// No dependencies; every other design file but hsrm_checker imports this package.
package hsrm_pkg;

  // Harmonic sum configuration.
  localparam int MAX_HARMONICS  = 256;
  localparam int COS_TABLE_BITS = 10;

  localparam int COS_N    = 1 << COS_TABLE_BITS;
  localparam int QTR_BITS = COS_TABLE_BITS - 2;
  localparam int QTR_N    = 1 << QTR_BITS;
  localparam int KIDX_W   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int KCNT_W   = $clog2(MAX_HARMONICS + 1);

  // Field and register widths.
  localparam int SMP_W      = 16;
  localparam int SEED_W     = 8;
  localparam int RATE_W     = 20;
  localparam int BASE_W     = 15;
  localparam int HC_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Datapath widths.
  localparam int D_W    = 24;              // 10 * sample_rate
  localparam int F_W    = 17;              // signed jittered frequency
  localparam int FA_W   = 16;              // frequency magnitude
  localparam int N_W    = 40;              // sample counter
  localparam int STEP_W = 6;
  localparam int TAB_W  = 17;              // unsigned Q16 table entry
  localparam int VAL_W  = 18;              // signed Q16 cosine value
  localparam int ACC_W  = 36;              // Q32 harmonic sum
  localparam int SUM_W  = ACC_W - 16;      // Q16 harmonic sum
  localparam int M2_W   = SUM_W + 1;
  localparam int P_W    = SMP_W + M2_W;
  localparam int PC_W   = 34;
  localparam int W_W    = PC_W + SMP_W;
  localparam int HW_W   = (HC_W > KCNT_W) ? HC_W : KCNT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HZ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARM_COUNT  = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RST = 20'd386000;
  localparam logic [BASE_W-1:0] BASE_RST = 15'd1200;
  localparam logic [HC_W-1:0]   HC_RST   = 9'd256;

  // A byte seed is always below 400, so the seed modulo 400 is the seed itself.
  localparam logic signed [F_W-1:0] JITTER_OFFSET = 17'sd200;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned COS_DIV [10] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};
  localparam longint unsigned SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef logic [TAB_W-1:0] qtab_t [QTR_N];
  typedef logic [TAB_W-1:0] rtab_t [MAX_HARMONICS];

  typedef struct packed {
    logic                      clr;
    logic                      vld;
    logic [COS_TABLE_BITS-1:0] idx;
    logic [KIDX_W-1:0]         kidx;
  } harm_ctl_t;

  typedef struct packed {
    logic dbl;
    logic add;
  } modd_ctl_t;

  typedef struct packed {
    logic qbit;
    logic carry;
  } modd_flag_t;

  function automatic logic [TAB_W-1:0] q30_to_q16(input longint v);
    longint unsigned u;
    u = (v < 0) ? 64'd0 : longint'(v);
    return TAB_W'((u + 64'd8192) >> 14);
  endfunction

  // Restoring shift-and-subtract quotient, used only while the tables are elaborated.
  function automatic longint unsigned udiv_const(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Quarter-wave cosine or sine in Q16, from an 11-term Taylor series in Q30.
  function automatic qtab_t build_qtab(input logic want_sin);
    qtab_t           t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint          c;
    longint          s;
    for (int j = 0; j < QTR_N; j++) begin
      x  = (longint'(j) * TWO_PI_Q30) >> COS_TABLE_BITS;
      x2 = (x * x) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      c  = longint'(tc);
      s  = longint'(ts);
      for (int n = 1; n <= 10; n++) begin
        tc = udiv_const((tc * x2) >> 30, COS_DIV[n-1]);
        ts = udiv_const((ts * x2) >> 30, SIN_DIV[n-1]);
        if ((n & 1) == 1) begin
          c = c - longint'(tc);
          s = s - longint'(ts);
        end else begin
          c = c + longint'(tc);
          s = s + longint'(ts);
        end
      end
      t[j] = want_sin ? q30_to_q16(s) : q30_to_q16(c);
    end
    return t;
  endfunction

  // Entry i holds the Q16 reciprocal of harmonic number i + 1, rounded.
  function automatic rtab_t build_rtab();
    rtab_t t;
    for (int k = 1; k <= MAX_HARMONICS; k++) begin
      t[k-1] = TAB_W'(udiv_const(longint'(65536 + (k >> 1)), longint'(k)));
    end
    return t;
  endfunction

  localparam qtab_t QCOS  = build_qtab(1'b0);
  localparam qtab_t QSIN  = build_qtab(1'b1);
  localparam rtab_t RECIP = build_rtab();

endpackage

/* design/hsrm_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample requests and results.
// Depends on hsrm_pkg for the field widths.
interface hsrm_in_if;
  import hsrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] in_sample;
  logic                    new_buffer;
  logic [SEED_W-1:0]       jitter_seed;

  modport source (output valid, output in_sample, output new_buffer, output jitter_seed,
                  input ready);
  modport sink   (input valid, input in_sample, input new_buffer, input jitter_seed,
                  output ready);
endinterface

interface hsrm_out_if;
  import hsrm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

/* design/harmonic_sum_ring_modulator_core.sv */
`timescale 1ns / 1ps
// Top level of the harmonic-sum ring modulator: sequencer, configuration and output stage.
// Depends on hsrm_pkg, hsrm_if, hsrm_modd_unit and hsrm_harm_pipe.
//
// Each sample request is multiplied by 0.5 + 0.5 * sum over k = 1..H of cos(k*phase)/k, where
// the phase follows a jittered fundamental and the running sample count, and the product is
// clamped to full scale and truncated toward zero. The block handles one request at a time:
// in_ch.ready is high only while the sequencer is idle, and a request is worked through by
// the single modulo-D adder, which runs 16 steps to reduce the frequency, 40 steps to form
// frequency times sample count modulo D and 10 steps to split the per-harmonic phase
// increment into table index and remainder, followed by the harmonic loop that advances one
// harmonic per cycle through the table and multiply pipeline; when H is zero the loop is
// skipped and the pipeline has nothing to drain. The result sits in an output register; when
// the consumer stalls, the last step of the next request waits for that register to empty.
// Configuration writes are taken at any time but must only be issued while the block is
// idle; they take effect on the next request and leave the sample count and the latched
// jitter seed untouched. A new_buffer request latches its jitter seed before its own
// frequency is formed.
module harmonic_sum_ring_modulator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  hsrm_in_if.sink                        in_ch,
  hsrm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [hsrm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hsrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hsrm_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FMOD   = 4'd1;
  localparam logic [3:0] S_NMOD   = 4'd2;
  localparam logic [3:0] S_MDIV   = 4'd3;
  localparam logic [3:0] S_HARM   = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_CLAMP  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  localparam logic signed [P_W-1:0]   P_LIM   = P_W'(64'sd4294967296);
  localparam logic signed [M2_W-1:0]  M2_HALF = M2_W'(65536);
  localparam logic signed [SMP_W-1:0] FULL_SCALE = 16'sd32767;

  // Configuration registers.
  logic [RATE_W-1:0] rate_r;
  logic [BASE_W-1:0] base_r;
  logic [HC_W-1:0]   hc_r;

  // Sequencer and datapath registers.
  logic [3:0]                state_r,  state_nxt;
  logic [STEP_W-1:0]         step_r,   step_nxt;
  logic [D_W-1:0]            d_r,      d_nxt;
  logic [D_W-1:0]            r_r,      r_nxt;
  logic [D_W-1:0]            a_r,      a_nxt;
  logic [N_W-1:0]            sh_r,     sh_nxt;
  logic [COS_TABLE_BITS-1:0] qm_r,     qm_nxt;
  logic [COS_TABLE_BITS-1:0] q_r,      q_nxt;
  logic [KCNT_W-1:0]         k_r,      k_nxt;
  logic [KCNT_W-1:0]         h_r,      h_nxt;
  logic signed [SMP_W-1:0]   smp_r,    smp_nxt;
  logic [SEED_W-1:0]         seed_r,   seed_nxt;
  logic [N_W-1:0]            n_r,      n_nxt;
  logic signed [P_W-1:0]     p_r,      p_nxt;
  logic signed [W_W-1:0]     w_r,      w_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic signed [SMP_W-1:0]   out_smp_r, out_smp_nxt;

  // Combinational helpers.
  logic                      in_acc;
  logic [SEED_W-1:0]         seed_eff;
  logic [RATE_W-1:0]         rate_eff;
  logic signed [F_W-1:0]     f_s;
  logic signed [F_W-1:0]     f_neg;
  logic [FA_W-1:0]           fa;
  logic [HW_W-1:0]           hc_ext;
  logic [D_W-1:0]            a_sel;
  modd_ctl_t                 mctl;
  modd_flag_t                mflag;
  logic [D_W-1:0]            r_mod;
  harm_ctl_t                 hctl;
  logic signed [ACC_W-1:0]   acc;
  logic                      pipe_busy;
  logic signed [SUM_W-1:0]   sum_s;
  logic signed [M2_W-1:0]    m2;
  logic signed [PC_W-1:0]    pc;
  logic signed [W_W-1:0]     wb;

  assign in_acc       = in_ch.valid & in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.out_sample = out_smp_r;

  hsrm_modd_unit u_modd (
    .d_i    (d_r),
    .r_i    (r_r),
    .a_i    (a_sel),
    .ctl_i  (mctl),
    .r_o    (r_mod),
    .flag_o (mflag)
  );

  hsrm_harm_pipe u_harm (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (hctl),
    .acc_o  (acc),
    .busy_o (pipe_busy)
  );

  // Frequency set-up for a new request. A zero sample rate is treated as one.
  always_comb begin
    seed_eff = in_ch.new_buffer ? in_ch.jitter_seed : seed_r;
    rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
    f_s      = signed'({2'b00, base_r}) + signed'({9'd0, seed_eff}) - JITTER_OFFSET;
    f_neg    = -f_s;
    // The cosine is even, so only the magnitude of the frequency matters.
    fa       = f_s[F_W-1] ? f_neg[FA_W-1:0] : f_s[FA_W-1:0];
    hc_ext   = HW_W'(hc_r);
  end

  // Final scaling helpers. The accumulator bound keeps the floored Q16 sum inside Q4.16,
  // so the shifted sum needs no saturation.
  always_comb begin
    sum_s = acc[ACC_W-1:16];
    m2    = M2_HALF + {sum_s[SUM_W-1], sum_s};
    if (p_r > P_LIM) begin
      pc = PC_W'(P_LIM);
    end else if (p_r < -P_LIM) begin
      pc = PC_W'(-P_LIM);
    end else begin
      pc = PC_W'(p_r);
    end
    // Bias negative products so the arithmetic shift truncates toward zero.
    wb = w_r + signed'({18'd0, (w_r[W_W-1] ? 32'hFFFF_FFFF : 32'd0)});
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    d_nxt       = d_r;
    r_nxt       = r_r;
    a_nxt       = a_r;
    sh_nxt      = sh_r;
    qm_nxt      = qm_r;
    q_nxt       = q_r;
    k_nxt       = k_r;
    h_nxt       = h_r;
    smp_nxt     = smp_r;
    seed_nxt    = seed_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    w_nxt       = w_r;
    out_smp_nxt = out_smp_r;
    out_vld_nxt = out_vld_r & ~out_ch.ready;
    a_sel       = a_r;
    mctl        = '0;
    hctl        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_nxt  = in_ch.in_sample;
          seed_nxt = seed_eff;
          d_nxt    = (D_W'(rate_eff) << 3) + (D_W'(rate_eff) << 1);
          sh_nxt   = {fa, {(N_W - FA_W){1'b0}}};
          r_nxt    = '0;
          step_nxt = '0;
          h_nxt    = (hc_ext > HW_W'(MAX_HARMONICS)) ? KCNT_W'(MAX_HARMONICS)
                                                     : KCNT_W'(hc_ext);
          hctl.clr = 1'b1;
          state_nxt = S_FMOD;
        end
      end

      // Frequency magnitude modulo D, one bit of the magnitude per cycle.
      S_FMOD: begin
        a_sel    = D_W'(1);
        mctl.dbl = 1'b1;
        mctl.add = sh_r[N_W-1];
        r_nxt    = r_mod;
        sh_nxt   = sh_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(FA_W - 1)) begin
          a_nxt     = r_mod;
          r_nxt     = '0;
          sh_nxt    = n_r;
          step_nxt  = '0;
          state_nxt = S_NMOD;
        end
      end

      // Phase increment m = frequency times sample count modulo D.
      S_NMOD: begin
        mctl.dbl = 1'b1;
        mctl.add = sh_r[N_W-1];
        r_nxt    = r_mod;
        sh_nxt   = sh_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(N_W - 1)) begin
          step_nxt  = '0;
          state_nxt = S_MDIV;
        end
      end

      // Split m * 2^COS_TABLE_BITS into a quotient by D and a remainder.
      S_MDIV: begin
        mctl.dbl = 1'b1;
        r_nxt    = r_mod;
        qm_nxt   = {qm_r[COS_TABLE_BITS-2:0], mflag.qbit};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(COS_TABLE_BITS - 1)) begin
          a_nxt     = r_mod;
          r_nxt     = '0;
          q_nxt     = '0;
          k_nxt     = KCNT_W'(1);
          step_nxt  = '0;
          state_nxt = (h_r == '0) ? S_DRAIN : S_HARM;
        end
      end

      // One harmonic per cycle: the remainder advances modulo D and its carry bumps the
      // table index; the index wraps exactly when the phase wraps past a full turn.
      S_HARM: begin
        mctl.add  = 1'b1;
        r_nxt     = r_mod;
        q_nxt     = q_r + qm_r + COS_TABLE_BITS'(mflag.carry);
        hctl.vld  = 1'b1;
        hctl.idx  = q_nxt;
        hctl.kidx = KIDX_W'(k_r - 1'b1);
        k_nxt     = k_r + 1'b1;
        if (k_r == h_r) begin
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = S_SCALE;
        end
      end

      S_SCALE: begin
        p_nxt     = smp_r * m2;
        state_nxt = S_CLAMP;
      end

      S_CLAMP: begin
        w_nxt     = pc * FULL_SCALE;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_vld_r || out_ch.ready) begin
          out_smp_nxt = wb[32 +: SMP_W];
          out_vld_nxt = 1'b1;
          n_nxt       = n_r + 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seed_r    <= '0;
      n_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seed_r    <= seed_nxt;
      n_r       <= n_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
      base_r <= BASE_RST;
      hc_r   <= HC_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RATE_HZ:     rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_BASE_FREQ:   base_r <= cfg_wdata[BASE_W-1:0];
        CFG_HARM_COUNT:  hc_r   <= cfg_wdata[HC_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    d_r       <= d_nxt;
    r_r       <= r_nxt;
    a_r       <= a_nxt;
    sh_r      <= sh_nxt;
    qm_r      <= qm_nxt;
    q_r       <= q_nxt;
    k_r       <= k_nxt;
    h_r       <= h_nxt;
    smp_r     <= smp_nxt;
    p_r       <= p_nxt;
    w_r       <= w_nxt;
    out_smp_r <= out_smp_nxt;
  end

endmodule

/* design/hsrm_modd_unit.sv */
`timescale 1ns / 1ps
// Shared modulo-D unit: optional doubling then optional addition, both reduced mod D.
// Depends on hsrm_pkg. Operands must already be below D.
module hsrm_modd_unit (
  input  logic [hsrm_pkg::D_W-1:0] d_i,
  input  logic [hsrm_pkg::D_W-1:0] r_i,
  input  logic [hsrm_pkg::D_W-1:0] a_i,
  input  hsrm_pkg::modd_ctl_t      ctl_i,
  output logic [hsrm_pkg::D_W-1:0] r_o,
  output hsrm_pkg::modd_flag_t     flag_o
);
  import hsrm_pkg::*;

  logic [D_W:0] t;
  logic [D_W:0] t1;
  logic [D_W:0] u;
  logic [D_W:0] d_ext;
  logic         ge1;
  logic         ge2;

  always_comb begin
    d_ext = {1'b0, d_i};
    t     = ctl_i.dbl ? {r_i, 1'b0} : {1'b0, r_i};
    ge1   = (t >= d_ext);
    t1    = ge1 ? (t - d_ext) : t;
    u     = t1 + (ctl_i.add ? {1'b0, a_i} : '0);
    ge2   = (u >= d_ext);
    r_o   = ge2 ? D_W'(u - d_ext) : D_W'(u);
    flag_o.qbit  = ge1;
    flag_o.carry = ge2;
  end

endmodule

/* design/hsrm_harm_pipe.sv */
`timescale 1ns / 1ps
// Harmonic accumulate pipeline: cosine and reciprocal table lookup, multiply, accumulate.
// Depends on hsrm_pkg for the tables and the control struct.
module hsrm_harm_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hsrm_pkg::harm_ctl_t             ctl_i,
  output logic signed [hsrm_pkg::ACC_W-1:0] acc_o,
  output logic                            busy_o
);
  import hsrm_pkg::*;

  localparam logic [1:0] QD_I   = 2'd0;
  localparam logic [1:0] QD_II  = 2'd1;
  localparam logic [1:0] QD_III = 2'd2;
  localparam logic [1:0] QD_IV  = 2'd3;

  logic                      s1_vld_r;
  logic [COS_TABLE_BITS-1:0] s1_idx_r;
  logic [KIDX_W-1:0]         s1_k_r;
  logic                      s2_vld_r;
  logic signed [VAL_W-1:0]   v_r;
  logic [TAB_W-1:0]          rc_r;
  logic                      s3_vld_r;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic [QTR_BITS-1:0]       j;
  logic signed [VAL_W-1:0]   cq;
  logic signed [VAL_W-1:0]   sq;
  logic signed [VAL_W-1:0]   v_nxt;

  always_comb begin
    j  = s1_idx_r[QTR_BITS-1:0];
    cq = signed'({1'b0, QCOS[j]});
    sq = signed'({1'b0, QSIN[j]});
    case (s1_idx_r[COS_TABLE_BITS-1 -: 2])
      QD_I:    v_nxt = cq;
      QD_II:   v_nxt = -sq;
      QD_III:  v_nxt = -cq;
      QD_IV:   v_nxt = sq;
      default: v_nxt = cq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl_i.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= ctl_i.idx;
    s1_k_r   <= ctl_i.kidx;
    v_r      <= v_nxt;
    rc_r     <= RECIP[s1_k_r];
    prod_r   <= ACC_W'(v_r * signed'({1'b0, rc_r}));
    if (ctl_i.clr) begin
      acc_r <= '0;
    end else if (s3_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc_o  = acc_r;
  assign busy_o = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule

/* design/hsrm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the harmonic-sum ring modulator, bound to the top level.
// Depends on harmonic_sum_ring_modulator_core and its channel interfaces.
module hsrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result changed or dropped while stalled");

  // One request at a time: the block is busy right after it takes a request.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  // A result never appears in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Clamping to full scale keeps the most negative code out of the results.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != 16'h8000)
    else $error("result outside the clamped range");

  // Reset leaves the block idle and ready.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind harmonic_sum_ring_modulator_core hsrm_checker u_hsrm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.out_sample)
);

/* sim/harmonic_sum_ring_modulator_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for harmonic_sum_ring_modulator_core: drives sample requests and
// register writes, predicts every modulated sample and checks it. Depends on hsrm_pkg and hsrm_if.
module harmonic_sum_ring_modulator_core_tb;
  import hsrm_pkg::*;

  localparam int TAB_N = 1 << COS_TABLE_BITS;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint FULL_SCALE = 64'sd4294967296;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 85;

  // Keeps its own copy of the registers, the sample counter and the latched seed, predicts
  // each modulated sample when its request is accepted and checks results in order.
  class modulator_scoreboard;
    logic [RATE_W-1:0] rate_reg;
    logic [BASE_W-1:0] base_reg;
    logic [HC_W-1:0]   harm_reg;
    logic [N_W-1:0]    sample_idx;
    logic [SEED_W-1:0] seed_reg;
    longint            cosine_q16 [TAB_N];
    longint            recip_q16 [MAX_HARMONICS + 1];
    logic signed [SMP_W-1:0] due_samples [$];
    int                errors;

    function longint round_q30(longint v);
      if (v < 0) v = 0;
      return (v + 8192) >>> 14;
    endfunction

    function new();
      longint unsigned x, x2, tc, ts;
      longint          c, s, cq, sq;
      int              quad, j;
      rate_reg   = RATE_RST;
      base_reg   = BASE_RST;
      harm_reg   = HC_RST;
      sample_idx = '0;
      seed_reg   = '0;
      errors     = 0;
      // Full-wave cosine table built from the quarter wave by quadrant.
      for (int i = 0; i < TAB_N; i++) begin
        quad = i / (TAB_N / 4);
        j    = i % (TAB_N / 4);
        x    = (longint'(j) * TWO_PI_Q30) / TAB_N;
        x2   = (x * x) >> 30;
        tc   = 64'd1 << 30;
        ts   = x;
        c    = longint'(tc);
        s    = longint'(ts);
        for (int n = 1; n <= 10; n++) begin
          tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
          ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            c = c - longint'(tc);
            s = s - longint'(ts);
          end else begin
            c = c + longint'(tc);
            s = s + longint'(ts);
          end
        end
        cq = round_q30(c);
        sq = round_q30(s);
        case (quad)
          0: cosine_q16[i] = cq;
          1: cosine_q16[i] = -sq;
          2: cosine_q16[i] = -cq;
          default: cosine_q16[i] = sq;
        endcase
      end
      recip_q16[0] = 0;
      for (int k = 1; k <= MAX_HARMONICS; k++) recip_q16[k] = (65536 + k / 2) / k;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RATE_HZ:     rate_reg = data[RATE_W-1:0];
        CFG_BASE_FREQ:   base_reg = data[BASE_W-1:0];
        CFG_HARM_COUNT:  harm_reg = data[HC_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [SMP_W-1:0] modulate_sample(logic signed [SMP_W-1:0] smp,
                                                      logic nb, logic [SEED_W-1:0] seed);
      longint unsigned d, fa, m, r, ph;
      longint          f, acc, sum16, p, o;
      int              h, idx;
      d = 10 * ((rate_reg == 0) ? 64'd1 : 64'(rate_reg));
      if (nb) seed_reg = seed;
      f  = longint'(base_reg) + longint'(seed_reg % 400) - 200;
      fa = (f < 0) ? -f : f;
      m  = ((fa % d) * 64'(sample_idx)) % d;
      h  = (harm_reg > MAX_HARMONICS) ? MAX_HARMONICS : int'(harm_reg);
      r   = 0;
      acc = 0;
      for (int k = 1; k <= h; k++) begin
        r = r + m;
        if (r >= d) r = r - d;
        ph  = (r << 32) / d;
        idx = int'(ph >> (32 - COS_TABLE_BITS)) & (TAB_N - 1);
        acc = acc + cosine_q16[idx] * recip_q16[k];
      end
      sum16 = acc >>> 16;
      if (sum16 > 524287) sum16 = 524287;
      if (sum16 < -524288) sum16 = -524288;
      p = longint'(smp) * (65536 + sum16);
      if (p > FULL_SCALE) p = FULL_SCALE;
      if (p < -FULL_SCALE) p = -FULL_SCALE;
      o = (p * 32767) / FULL_SCALE;
      sample_idx = sample_idx + 1'b1;
      return o[SMP_W-1:0];
    endfunction

    function void note_request(logic signed [SMP_W-1:0] smp, logic nb, logic [SEED_W-1:0] seed);
      due_samples.push_back(modulate_sample(smp, nb, seed));
    endfunction

    function void check_result(logic signed [SMP_W-1:0] actual);
      logic signed [SMP_W-1:0] want;
      if (due_samples.size() == 0) begin
        $error("out_sample: got %0d with no request outstanding", actual);
        errors++;
      end else begin
        want = due_samples.pop_front();
        if (actual !== want) begin
          $error("out_sample: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hsrm_in_if  in_ch ();
  hsrm_out_if out_ch ();

  harmonic_sum_ring_modulator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  modulator_scoreboard sb = new();

  // Idle percentages of the current phase, and a long consumer hold-off counted down by the
  // consumer process itself.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Request and result monitors sample at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.in_sample, in_ch.new_buffer, in_ch.jitter_seed);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.out_sample);
  end

  // Watchdog: a long stretch with no handshake and no register write means the block
  // has hung.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[harmonic_sum_ring_modulator_core] ERROR");
        $finish;
      end
    end
  end

  // Result consumer: either in a long hold-off or stalling at random.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_request(input logic signed [SMP_W-1:0] smp, input logic nb,
                              input logic [SEED_W-1:0] seed);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    // Now and then a long gap, so the next request lands on a different point of the loop.
    if (gap > 0 && $urandom_range(9) == 0) gap += $urandom_range(1, 400);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_sample   <= smp;
    in_ch.new_buffer  <= nb;
    in_ch.jitter_seed <= seed;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering requests until every predicted sample has come back, then let the
  // sequencer settle before any register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.due_samples.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_random_request();
    logic signed [SMP_W-1:0] smp;
    smp = SMP_W'($urandom);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: smp = 16'sh7FFF;
        1: smp = 16'sh8000;
        2: smp = 16'sh0000;
        default: smp = 16'shFFFF;
      endcase
    end
    // Buffers of a few to a few dozen samples, each opened by a fresh jitter byte.
    send_request(smp, $urandom_range(15) == 0, SEED_W'($urandom));
  endtask

  task automatic randomize_regs();
    case ($urandom_range(4))
      0: write_reg(CFG_RATE_HZ, 20'd8000);
      1: write_reg(CFG_RATE_HZ, 20'd1000000);
      2: write_reg(CFG_RATE_HZ, CFG_DATA_W'($urandom_range(8000, 1000000)));
      3: write_reg(CFG_RATE_HZ, CFG_DATA_W'($urandom));
      default: write_reg(CFG_RATE_HZ, CFG_DATA_W'($urandom_range(8000, 48000)));
    endcase
    case ($urandom_range(3))
      0: write_reg(CFG_BASE_FREQ, 20'd0);
      1: write_reg(CFG_BASE_FREQ, 20'd20000);
      2: write_reg(CFG_BASE_FREQ, CFG_DATA_W'($urandom_range(0, 20000)));
      default: write_reg(CFG_BASE_FREQ, CFG_DATA_W'($urandom_range(0, 32767)));
    endcase
    // Short harmonic sums keep most phases quick; full and oversized counts still show up.
    case ($urandom_range(5))
      0: write_reg(CFG_HARM_COUNT, 20'd256);
      1: write_reg(CFG_HARM_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
      2: write_reg(CFG_HARM_COUNT, CFG_DATA_W'($urandom_range(1, 64)));
      3: write_reg(CFG_HARM_COUNT, CFG_DATA_W'($urandom_range(257, 511)));
      4: write_reg(CFG_HARM_COUNT, 20'd0);
      default: write_reg(CFG_HARM_COUNT, CFG_DATA_W'($urandom_range(1, 256)));
    endcase
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.in_sample   = '0;
    in_ch.new_buffer  = 1'b0;
    in_ch.jitter_seed = '0;
    out_ch.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: full-scale samples of both signs, zero, and seeds around the point
    // where the jitter changes sign.
    send_request(16'sh7FFF, 1'b1, 8'd0);
    send_request(16'sh8000, 1'b0, 8'd77);
    send_request(16'sh0000, 1'b0, 8'd0);
    send_request(16'sh0001, 1'b1, 8'd255);
    send_request(16'shFFFF, 1'b0, 8'd0);
    send_request(16'sh4000, 1'b1, 8'd200);
    send_request(-16'sh4000, 1'b1, 8'd199);
    drain();

    // Zero sample rate counts as one, no harmonics gives exactly half scale, and a zero base
    // with a low seed gives a negative fundamental.
    write_reg(CFG_RATE_HZ, 20'd0);
    write_reg(CFG_BASE_FREQ, 20'd0);
    write_reg(CFG_HARM_COUNT, 20'd0);
    send_request(16'sh7FFF, 1'b1, 8'd0);
    send_request(16'sh8000, 1'b0, 8'd0);
    send_request(16'sh3039, 1'b1, 8'd255);
    drain();

    // Largest register values: the harmonic count saturates at its maximum, and a write to
    // the unused index must change nothing.
    write_reg(CFG_RATE_HZ, 20'hFFFFF);
    write_reg(CFG_BASE_FREQ, 20'd32767);
    write_reg(CFG_HARM_COUNT, 20'd511);
    write_reg(CFG_UNUSED_IDX, 20'hFFFFF);
    send_request(16'sh7FFF, 1'b1, 8'd128);
    send_request(16'sh8000, 1'b0, 8'd0);
    send_request(16'sh5555, 1'b0, 8'd0);
    send_request(-16'sh5556, 1'b1, 8'd1);
    drain();

    // Lowest in-range rate with the highest in-range base and a single harmonic.
    write_reg(CFG_RATE_HZ, 20'd8000);
    write_reg(CFG_BASE_FREQ, 20'd20000);
    write_reg(CFG_HARM_COUNT, 20'd1);
    send_request(16'sh7FFF, 1'b1, 8'd255);
    send_request(16'sh8000, 1'b0, 8'd0);
    send_request(16'sh2AAA, 1'b0, 8'd0);
    send_request(16'shD555, 1'b1, 8'd0);
    drain();

    // Random phases cycle through the idle patterns: none, idle producer, stalling
    // consumer, and a little of both.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      randomize_regs();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      if (ph == 0) begin
        // The consumer holds off while requests keep coming, so the output register fills
        // and the block has to stall its input.
        @(posedge clk);
        rx_hold_left = 3000;
        @(negedge clk);
      end
      repeat (PHASE_ITEMS) send_random_request();
      drain();
    end

    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.due_samples.size() == 0) begin
      $display("[harmonic_sum_ring_modulator_core] OK");
    end else begin
      $display("[harmonic_sum_ring_modulator_core] ERROR");
    end
    $finish;
  end

endmodule
